FILE: rtl/core/tzoff_pkg.sv
// Shared types and constants for the POSIX TZ offset parser.
package tzoff_pkg;

    localparam int CHAR_W   = 8;
    localparam int ACC_W    = 8;
    localparam int TOTAL_W  = 20;
    localparam int OFFSET_W = 21;

    localparam logic [ACC_W-1:0] ACC_MAX = 8'd255;

    localparam logic [TOTAL_W-1:0] SECS_PER_HOUR   = 20'd3600;
    localparam logic [TOTAL_W-1:0] SECS_PER_MINUTE = 20'd60;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;

    typedef struct packed {
        logic             negative;
        logic [ACC_W-1:0] hours;
        logic [ACC_W-1:0] minutes;
        logic [ACC_W-1:0] seconds;
    } tzoff_fields_t;

endpackage

FILE: rtl/core/tzoff_parser.sv
// Input register and per-character parsing state of the TZ offset parser.
module tzoff_parser
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [tzoff_pkg::CHAR_W-1:0]     character,
    input  logic                             last,
    input  logic                             out_free,
    output logic                             fire,
    output tzoff_pkg::tzoff_fields_t         fields
);

    localparam logic [2:0] PH_LETTERS = 3'd0;
    localparam logic [2:0] PH_HOURS   = 3'd1;
    localparam logic [2:0] PH_MINUTES = 3'd2;
    localparam logic [2:0] PH_SECONDS = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    logic                          s1_valid_reg;
    logic [tzoff_pkg::CHAR_W-1:0]  char_reg;
    logic                          last_reg;

    logic [2:0]                    phase_reg;
    logic [2:0]                    phase_next;
    logic                          negative_reg;
    logic                          negative_next;
    logic [tzoff_pkg::ACC_W-1:0]   hours_reg;
    logic [tzoff_pkg::ACC_W-1:0]   hours_next;
    logic [tzoff_pkg::ACC_W-1:0]   minutes_reg;
    logic [tzoff_pkg::ACC_W-1:0]   minutes_next;
    logic [tzoff_pkg::ACC_W-1:0]   seconds_reg;
    logic [tzoff_pkg::ACC_W-1:0]   seconds_next;

    logic                          in_accept;
    logic                          advance;
    logic                          is_digit;
    logic                          is_letter;
    logic [3:0]                    digit_val;

    function automatic logic [tzoff_pkg::ACC_W-1:0] acc_digit(
        input logic [tzoff_pkg::ACC_W-1:0] acc,
        input logic [3:0]                  digit
    );
        logic [11:0] v;
        v = 12'(acc) * 12'd10 + 12'(digit);
        if (v > 12'(tzoff_pkg::ACC_MAX))
        begin
            return tzoff_pkg::ACC_MAX;
        end
        return v[tzoff_pkg::ACC_W-1:0];
    endfunction

    // An item that ends a string needs room in the result register.
    assign advance    = s1_valid_reg && (!last_reg || out_free);
    assign item_stall = s1_valid_reg && !advance;
    assign in_accept  = item_valid && !item_stall;
    assign fire       = advance && last_reg;

    assign is_digit  = (char_reg >= tzoff_pkg::CHAR_ZERO) && (char_reg <= tzoff_pkg::CHAR_NINE);
    assign is_letter = ((char_reg >= tzoff_pkg::CHAR_UC_A) && (char_reg <= tzoff_pkg::CHAR_UC_Z))
                    || ((char_reg >= tzoff_pkg::CHAR_LC_A) && (char_reg <= tzoff_pkg::CHAR_LC_Z));
    assign digit_val = 4'(char_reg - tzoff_pkg::CHAR_ZERO);

    always_comb
    begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        hours_next    = hours_reg;
        minutes_next  = minutes_reg;
        seconds_next  = seconds_reg;
        unique case (phase_reg)
            PH_LETTERS:
            begin
                if (is_letter)
                begin
                    phase_next = PH_LETTERS;
                end
                else if (char_reg == tzoff_pkg::CHAR_MINUS)
                begin
                    negative_next = 1'b1;
                    phase_next    = PH_HOURS;
                end
                else if (char_reg == tzoff_pkg::CHAR_PLUS)
                begin
                    phase_next = PH_HOURS;
                end
                else if (is_digit)
                begin
                    hours_next = acc_digit(hours_reg, digit_val);
                    phase_next = PH_HOURS;
                end
                else if (char_reg == tzoff_pkg::CHAR_COLON)
                begin
                    phase_next = PH_MINUTES;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_HOURS:
            begin
                if (is_digit)
                begin
                    hours_next = acc_digit(hours_reg, digit_val);
                end
                else if (char_reg == tzoff_pkg::CHAR_COLON)
                begin
                    phase_next = PH_MINUTES;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_MINUTES:
            begin
                if (is_digit)
                begin
                    minutes_next = acc_digit(minutes_reg, digit_val);
                end
                else if (char_reg == tzoff_pkg::CHAR_COLON)
                begin
                    phase_next = PH_SECONDS;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_SECONDS:
            begin
                if (is_digit)
                begin
                    seconds_next = acc_digit(seconds_reg, digit_val);
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign fields.negative = negative_next;
    assign fields.hours    = hours_next;
    assign fields.minutes  = minutes_next;
    assign fields.seconds  = seconds_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            char_reg <= character;
            last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LETTERS;
            negative_reg <= 1'b0;
            hours_reg    <= '0;
            minutes_reg  <= '0;
            seconds_reg  <= '0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                phase_reg    <= PH_LETTERS;
                negative_reg <= 1'b0;
                hours_reg    <= '0;
                minutes_reg  <= '0;
                seconds_reg  <= '0;
            end
            else
            begin
                phase_reg    <= phase_next;
                negative_reg <= negative_next;
                hours_reg    <= hours_next;
                minutes_reg  <= minutes_next;
                seconds_reg  <= seconds_next;
            end
        end
    end

`ifndef SYNTH
    // Every string starts from a clean state once its final item has been used.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (phase_reg == PH_LETTERS) && !negative_reg && (hours_reg == '0))
    else $error("parser state not cleared after the final item of a string");

    // Nothing is accumulated while still skipping the zone name.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LETTERS) |-> !negative_reg && (hours_reg == '0)
            && (minutes_reg == '0) && (seconds_reg == '0))
    else $error("accumulator set while skipping letters");

    // Minutes and seconds only grow once the hours group has been left.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((minutes_reg != '0) || (seconds_reg != '0))
            |-> (phase_reg != PH_LETTERS) && (phase_reg != PH_HOURS))
    else $error("minutes or seconds set before the hours group ended");
`endif

endmodule

FILE: rtl/core/tzoff_result.sv
// Offset arithmetic and result register of the TZ offset parser.
module tzoff_result
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   fire,
    input  tzoff_pkg::tzoff_fields_t               fields,
    output logic                                   out_free,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [tzoff_pkg::OFFSET_W-1:0]  offset_seconds
);

    logic                                  result_valid_reg;
    logic signed [tzoff_pkg::OFFSET_W-1:0] offset_reg;
    logic signed [tzoff_pkg::OFFSET_W-1:0] offset_next;
    logic [tzoff_pkg::TOTAL_W-1:0]         total;

    assign total = tzoff_pkg::TOTAL_W'(fields.hours) * tzoff_pkg::SECS_PER_HOUR
                 + tzoff_pkg::TOTAL_W'(fields.minutes) * tzoff_pkg::SECS_PER_MINUTE
                 + tzoff_pkg::TOTAL_W'(fields.seconds);

    // The POSIX sign is inverted: a '-' gives a positive offset.
    assign offset_next = fields.negative ? $signed({1'b0, total})
                                         : -$signed({1'b0, total});

    assign out_free       = !result_valid_reg || !result_stall;
    assign result_valid   = result_valid_reg;
    assign offset_seconds = offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            offset_reg <= offset_next;
        end
    end

`ifndef SYNTH
    // A finished string never overwrites a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && result_valid_reg && result_stall))
    else $error("result overwritten while stalled");

    // The offset stays within what three saturated groups can give.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (offset_reg <= 21'sd933555) && (offset_reg >= -21'sd933555))
    else $error("offset out of range");
`endif

endmodule

FILE: rtl/core/posix_tz_offset_parser.sv
// Top level of the POSIX TZ offset parser.
// The result register takes the last item from the input register when it is free.
// Throughput: one item per cycle; an item that gives no result never waits on the output.
// The rate is set by the single parsing stage between the input and result registers.
// Reset is asynchronous and active low; it clears the parsing state and both valid flags.
module posix_tz_offset_parser
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic [tzoff_pkg::CHAR_W-1:0]           character,
    input  logic                                   last,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [tzoff_pkg::OFFSET_W-1:0]  offset_seconds
);

    logic                     fire;
    logic                     out_free;
    tzoff_pkg::tzoff_fields_t fields;

    tzoff_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .character  (character),
        .last       (last),
        .out_free   (out_free),
        .fire       (fire),
        .fields     (fields)
    );

    tzoff_result u_result
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .fields         (fields),
        .out_free       (out_free),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .offset_seconds (offset_seconds)
    );

endmodule

FILE: tb/sv/posix_tz_offset_parser_tb.sv
// Self-checking bench, POSIX TZ offset parser; random idling on both sides in early tests.
module posix_tz_offset_parser_tb;

    typedef enum logic [2:0] {
        SKIP_LETTERS = 3'd0,
        IN_HOURS     = 3'd1,
        IN_MINUTES   = 3'd2,
        IN_SECONDS   = 3'd3,
        PARSE_DONE   = 3'd4
    } tz_phase_t;

    localparam int ITEM_TARGET = 550;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   item_valid;
    logic                                   item_stall;
    logic [tzoff_pkg::CHAR_W-1:0]           character;
    logic                                   last;
    logic                                   result_valid;
    logic                                   result_stall;
    logic signed [tzoff_pkg::OFFSET_W-1:0]  offset_seconds;

    tz_phase_t                              tz_phase;
    logic                                   tz_negative;
    logic [tzoff_pkg::ACC_W-1:0]            tz_groups [3];

    logic signed [tzoff_pkg::OFFSET_W-1:0]  expected_offsets [$];
    logic signed [tzoff_pkg::OFFSET_W-1:0]  oldest_offset;
    logic [tzoff_pkg::CHAR_W-1:0]           tz_text [$];
    int                                     mismatch_count;
    int                                     items_sent;
    bit                                     idling_on;

    posix_tz_offset_parser dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .character      (character),
        .last           (last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .offset_seconds (offset_seconds)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic bit is_digit_char(logic [tzoff_pkg::CHAR_W-1:0] c);
        return c >= tzoff_pkg::CHAR_ZERO && c <= tzoff_pkg::CHAR_NINE;
    endfunction

    function automatic bit is_letter_char(logic [tzoff_pkg::CHAR_W-1:0] c);
        return (c >= tzoff_pkg::CHAR_UC_A && c <= tzoff_pkg::CHAR_UC_Z)
            || (c >= tzoff_pkg::CHAR_LC_A && c <= tzoff_pkg::CHAR_LC_Z);
    endfunction

    function automatic void clear_tz_state();
        tz_phase    = SKIP_LETTERS;
        tz_negative = 1'b0;
        tz_groups[0] = '0;
        tz_groups[1] = '0;
        tz_groups[2] = '0;
    endfunction

    // Feeds one digit into the group that the current phase is collecting, or steps the phase.
    function automatic void step_digit_group(logic [tzoff_pkg::CHAR_W-1:0] c);
        int           g;
        int unsigned  v;
        g = int'(tz_phase) - int'(IN_HOURS);
        if (is_digit_char(c))
        begin
            v = tz_groups[g] * 10 + (c - tzoff_pkg::CHAR_ZERO);
            tz_groups[g] = (v > tzoff_pkg::ACC_MAX) ? tzoff_pkg::ACC_MAX
                                                    : v[tzoff_pkg::ACC_W-1:0];
        end
        else if (c == tzoff_pkg::CHAR_COLON && tz_phase != IN_SECONDS)
            tz_phase = tz_phase_t'(tz_phase + 3'd1);
        else
            tz_phase = PARSE_DONE;
    endfunction

    function automatic void parse_tz_char(logic [tzoff_pkg::CHAR_W-1:0] c, logic is_last);
        logic [tzoff_pkg::TOTAL_W-1:0]  total;
        logic [tzoff_pkg::OFFSET_W-1:0] magnitude;
        case (tz_phase)
            SKIP_LETTERS:
            begin
                if (is_letter_char(c))
                    tz_phase = SKIP_LETTERS;
                else if (c == tzoff_pkg::CHAR_MINUS)
                begin
                    tz_negative = 1'b1;
                    tz_phase    = IN_HOURS;
                end
                else if (c == tzoff_pkg::CHAR_PLUS)
                    tz_phase = IN_HOURS;
                else
                begin
                    tz_phase = IN_HOURS;
                    step_digit_group(c);
                end
            end
            IN_HOURS, IN_MINUTES, IN_SECONDS:
                step_digit_group(c);
            default:
                tz_phase = tz_phase;
        endcase
        if (is_last)
        begin
            total = tzoff_pkg::TOTAL_W'(tz_groups[0]) * tzoff_pkg::SECS_PER_HOUR
                  + tzoff_pkg::TOTAL_W'(tz_groups[1]) * tzoff_pkg::SECS_PER_MINUTE
                  + tzoff_pkg::TOTAL_W'(tz_groups[2]);
            magnitude = {1'b0, total};
            expected_offsets.push_back(tz_negative ? magnitude : -magnitude);
            clear_tz_state();
        end
    endfunction

    task automatic send_item(logic [tzoff_pkg::CHAR_W-1:0] c, logic is_last);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        item_valid <= 1'b1;
        character  <= c;
        last       <= is_last;
        do
            @(posedge clk);
        while (item_stall);
        parse_tz_char(c, is_last);
        items_sent++;
    endtask

    task automatic send_string();
        foreach (tz_text[i])
            send_item(tz_text[i], i == tz_text.size() - 1);
    endtask

    task automatic put_text(string s);
        tz_text.delete();
        for (int i = 0; i < s.len(); i++)
            tz_text.push_back(s[i]);
    endtask

    task automatic put_digits(int count);
        repeat (count)
            tz_text.push_back(8'(tzoff_pkg::CHAR_ZERO + $urandom_range(0, 9)));
    endtask

    // Builds a string that follows the grammar, sometimes with a broken or noisy tail.
    task automatic make_well_formed();
        int                           sel;
        logic [tzoff_pkg::CHAR_W-1:0] letter;
        tz_text.delete();
        repeat ($urandom_range(0, 5))
        begin
            letter = $urandom_range(0, 1) ? tzoff_pkg::CHAR_UC_A : tzoff_pkg::CHAR_LC_A;
            tz_text.push_back(8'(letter + $urandom_range(0, 25)));
        end
        sel = $urandom_range(0, 2);
        if (sel == 1)
            tz_text.push_back(tzoff_pkg::CHAR_PLUS);
        else if (sel == 2)
            tz_text.push_back(tzoff_pkg::CHAR_MINUS);
        put_digits(($urandom_range(0, 7) == 0) ? $urandom_range(3, 4) : $urandom_range(0, 2));
        if ($urandom_range(0, 3) != 0)
        begin
            tz_text.push_back(tzoff_pkg::CHAR_COLON);
            put_digits(($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2));
            if ($urandom_range(0, 2) != 0)
            begin
                tz_text.push_back(tzoff_pkg::CHAR_COLON);
                put_digits(($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2));
            end
        end
        sel = $urandom_range(0, 9);
        if (sel == 0)
            tz_text.push_back(8'h00);
        else if (sel == 1)
            tz_text.push_back($urandom_range(0, 1) ? tzoff_pkg::CHAR_PLUS
                                                   : tzoff_pkg::CHAR_MINUS);
        else if (sel == 2)
            tz_text.push_back(tzoff_pkg::CHAR_COLON);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                tz_text.push_back(8'($urandom_range(0, 255)));
        if (tz_text.size() == 0)
            tz_text.push_back(tzoff_pkg::CHAR_UC_A);
    endtask

    task automatic test_special_strings();
        put_text("A");
        send_string();
        put_text("-999:999:999");
        send_string();
        put_text(":5");
        send_string();
        put_text("1+2");
        send_string();
        put_text("3:4:5:6");
        send_string();
        tz_text.delete();
        tz_text.push_back(8'h00);
        send_string();
        tz_text.delete();
        tz_text.push_back(8'hFF);
        send_string();
    endtask

    task automatic test_well_formed_strings(int item_limit);
        while (items_sent < item_limit)
        begin
            make_well_formed();
            send_string();
        end
    endtask

    task automatic test_noise_strings(int item_limit);
        while (items_sent < item_limit)
        begin
            tz_text.delete();
            repeat ($urandom_range(1, 8))
                tz_text.push_back(8'($urandom_range(0, 255)));
            send_string();
        end
    endtask

    task automatic test_without_idling(int item_limit);
        idling_on = 1'b0;
        while (items_sent < item_limit)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                tz_text.delete();
                repeat ($urandom_range(1, 6))
                    tz_text.push_back(8'($urandom_range(0, 255)));
            end
            else
                make_well_formed();
            send_string();
        end
    endtask

    task automatic report_mismatch(string what, logic signed [tzoff_pkg::OFFSET_W-1:0] want,
                                   logic signed [tzoff_pkg::OFFSET_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected %0d, got %0d", what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_offsets.size() == 0)
                report_mismatch("Unexpected offset item", '0, offset_seconds);
            else
            begin
                oldest_offset = expected_offsets.pop_front();
                if (offset_seconds !== oldest_offset)
                    report_mismatch("Offset mismatch", oldest_offset, offset_seconds);
            end
        end
    end

    initial
    begin
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 9) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        character      = '0;
        last           = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        idling_on      = 1'b1;
        clear_tz_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_strings();
        test_well_formed_strings(400);
        test_noise_strings(470);
        test_without_idling(ITEM_TARGET);
        item_valid <= 1'b0;

        while (expected_offsets.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && expected_offsets.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
